FILE: rtl/c2p_pkg.sv
// Shared constants and types for the Cartesian-to-polar converter.
`default_nettype none

package c2p_pkg;

  // Fixed-point layout of the CORDIC datapath
  localparam int GUARD_BITS = 28;           // fraction bits below the integer coordinate
  localparam int Z_FRAC     = 16;           // fraction bits of the angle accumulator
  localparam int ATAN_W     = 23;           // width of one arctangent table entry
  localparam int ZW         = ATAN_W + 2;   // signed angle accumulator width
  localparam int TABLE_LEN  = 32;

  localparam logic [ATAN_W-1:0] DEG90_Z = 23'd5898240;   // 90 degrees in Q16

  // Whole-degree landmarks used when unfolding the quadrant
  localparam int DEG90  = 90;
  localparam int DEG180 = 180;
  localparam int DEG270 = 270;
  localparam int DEG360 = 360;

  // atan(2^-i) in degrees, Q16, rounded to nearest
  localparam logic [ATAN_W-1:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
    23'd234379,  23'd117304,  23'd58666,  23'd29335,
    23'd14668,   23'd7334,    23'd3667,   23'd1833,
    23'd917,     23'd458,     23'd229,    23'd115,
    23'd57,      23'd29,      23'd14,     23'd7,
    23'd4,       23'd2,       23'd1,      23'd0,
    23'd0,       23'd0,       23'd0,      23'd0,
    23'd0,       23'd0,       23'd0,      23'd0
  };

  // Sign and axis information of one point, carried beside the CORDIC chain
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic x_zero;
    logic y_zero;
  } quad_flags_t;

endpackage

`default_nettype wire

FILE: rtl/c2p_cordic_cell.sv
// One vectoring CORDIC stage: a fixed shift, one rotation step, registered.
`default_nettype none

module c2p_cordic_cell #(
  parameter int XW    = 46,
  parameter int STAGE = 0
) (
  input  wire                             clk,
  input  wire                             en,
  input  wire signed [XW-1:0]             x_in,
  input  wire signed [XW-1:0]             y_in,
  input  wire signed [c2p_pkg::ZW-1:0]    z_in,
  output logic signed [XW-1:0]            x_out,
  output logic signed [XW-1:0]            y_out,
  output logic signed [c2p_pkg::ZW-1:0]   z_out
);
  import c2p_pkg::*;

  localparam logic signed [ZW-1:0] STEP = signed'({2'b00, ATAN_DEG_Q16[STAGE]});

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  // arithmetic shift floors toward minus infinity
  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[XW-1]) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + STEP;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - STEP;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/c2p_sqrt_cell.sv
// One digit of the exact integer square root: trial subtract, registered.
`default_nettype none

module c2p_sqrt_cell #(
  parameter int RW  = 16,
  parameter int BIT = 0
) (
  input  wire                 clk,
  input  wire                 en,
  input  wire [2*RW-1:0]      rem_in,
  input  wire [RW-1:0]        root_in,
  output logic [2*RW-1:0]     rem_out,
  output logic [RW-1:0]       root_out
);

  localparam int NW = 2 * RW;

  logic [NW:0] trial;
  logic [NW:0] diff;

  // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
  assign trial = ((NW+1)'(root_in) << (BIT + 1)) + ((NW+1)'(1) << (2 * BIT));
  assign diff  = {1'b0, rem_in} - trial;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!diff[NW]) begin
        rem_out  <= diff[NW-1:0];
        root_out <= root_in | (RW'(1) << BIT);
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/c2p_delay.sv
// Enabled delay line that lines up the two result paths.
`default_nettype none

module c2p_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire              clk,
  input  wire              en,
  input  wire [WIDTH-1:0]  d,
  output logic [WIDTH-1:0] q
);

  generate
    if (DEPTH == 0) begin : g_none
      assign q = d;
    end else begin : g_line
      logic [WIDTH-1:0] taps [DEPTH];

      always_ff @(posedge clk) begin
        if (en) begin
          taps[0] <= d;
          for (int i = 1; i < DEPTH; i++) begin
            taps[i] <= taps[i-1];
          end
        end
      end

      assign q = taps[DEPTH-1];
    end
  endgenerate

endmodule

`default_nettype wire

FILE: rtl/c2p_out_buf.sv
// Two-entry output queue that keeps the pipeline moving while a result waits.
`default_nettype none

module c2p_out_buf #(
  parameter int WIDTH = 34
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire [WIDTH-1:0]  push_data,
  output logic             space,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign pop       = out_valid & out_ready;
  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> space)
    else $error("result pushed into a full output queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> (count != 2'd3))
    else $error("output queue count out of range");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 2'd1))
    else $error("transfer out did not drain the output queue");

endmodule

`default_nettype wire

FILE: rtl/cartesian_to_polar_top.sv
// Top level of the pipelined Cartesian-to-polar converter.
`default_nettype none

// Converts a signed point (x_coord, y_coord) to its rounded radius and its angle in
// degrees (ANGLE_FRAC_BITS fraction bits, 0 up to just under 360). One point can be
// taken every clock cycle; the angle comes from a chain of CORDIC_STAGES vectoring
// cells and the radius from a chain of COORD_WIDTH exact square-root digit cells, both
// running side by side. A two-entry output queue absorbs back-pressure; the whole
// pipeline holds only once that queue is full, and in_ready drops with it.
module cartesian_to_polar_top #(
  parameter int COORD_WIDTH     = 16,
  parameter int CORDIC_STAGES   = 18,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire signed [COORD_WIDTH-1:0]      x_coord,
  input  wire signed [COORD_WIDTH-1:0]      y_coord,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [COORD_WIDTH-1:0]            radius,
  output logic [ANGLE_FRAC_BITS+8:0]        angle_deg_q8,
  output logic                              radius_zero
);
  import c2p_pkg::*;

  localparam int W       = COORD_WIDTH;
  localparam int NW      = 2 * W;
  localparam int AW      = ANGLE_FRAC_BITS + 9;
  localparam int XW      = W + GUARD_BITS + 2;
  localparam int RAD_LAT = W + 4;
  localparam int ANG_LAT = CORDIC_STAGES + 3;
  localparam int TOT     = (RAD_LAT > ANG_LAT) ? RAD_LAT : ANG_LAT;
  localparam int SH      = (ANGLE_FRAC_BITS < Z_FRAC) ? (Z_FRAC - ANGLE_FRAC_BITS) : 0;
  localparam int OUT_W   = W + AW + 1;

  localparam logic [AW-1:0] A90  = AW'(DEG90)  << ANGLE_FRAC_BITS;
  localparam logic [AW-1:0] A180 = AW'(DEG180) << ANGLE_FRAC_BITS;
  localparam logic [AW-1:0] A270 = AW'(DEG270) << ANGLE_FRAC_BITS;
  localparam logic [AW-1:0] A360 = AW'(DEG360) << ANGLE_FRAC_BITS;

  logic           en;
  logic           in_xfer;
  logic [TOT-1:0] vld;

  assign in_ready = en;
  assign in_xfer  = in_valid & en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT-2:0], in_xfer};
    end
  end

  // ---- entry stage: magnitudes and quadrant flags
  logic [W-1:0] ax;
  logic [W-1:0] ay;
  quad_flags_t  flags_a;

  always_ff @(posedge clk) begin
    if (en) begin
      ax             <= x_coord[W-1] ? (~x_coord + W'(1)) : x_coord;
      ay             <= y_coord[W-1] ? (~y_coord + W'(1)) : y_coord;
      flags_a.x_neg  <= x_coord[W-1];
      flags_a.y_neg  <= y_coord[W-1];
      flags_a.x_zero <= (x_coord == '0);
      flags_a.y_zero <= (y_coord == '0);
    end
  end

  // ---- radius path: squares, sum, digit chain, rounding
  logic [NW-1:0] sq_x;
  logic [NW-1:0] sq_y;
  logic [NW-1:0] n_sum;
  logic [NW-1:0] rem_c  [W+1];
  logic [W-1:0]  root_c [W+1];
  logic [W-1:0]  rad;
  logic [W-1:0]  rad_al;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x  <= NW'(ax) * NW'(ax);
      sq_y  <= NW'(ay) * NW'(ay);
      n_sum <= sq_x + sq_y;
    end
  end

  assign rem_c[0]  = n_sum;
  assign root_c[0] = '0;

  generate
    for (genvar k = 0; k < W; k++) begin : g_sqrt
      c2p_sqrt_cell #(
        .RW  (W),
        .BIT (W - 1 - k)
      ) u_cell (
        .clk      (clk),
        .en       (en),
        .rem_in   (rem_c[k]),
        .root_in  (root_c[k]),
        .rem_out  (rem_c[k+1]),
        .root_out (root_c[k+1])
      );
    end
  endgenerate

  // remainder above the root means the true root lies past the half step
  always_ff @(posedge clk) begin
    if (en) begin
      rad <= (rem_c[W] > NW'(root_c[W])) ? (root_c[W] + W'(1)) : root_c[W];
    end
  end

  c2p_delay #(
    .WIDTH (W),
    .DEPTH (TOT - RAD_LAT)
  ) u_rad_pad (
    .clk (clk),
    .en  (en),
    .d   (rad),
    .q   (rad_al)
  );

  // ---- angle path: CORDIC chain in the first quadrant
  logic signed [XW-1:0] cx [CORDIC_STAGES+1];
  logic signed [XW-1:0] cy [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz [CORDIC_STAGES+1];

  assign cx[0] = signed'({2'b00, ax, {GUARD_BITS{1'b0}}});
  assign cy[0] = signed'({2'b00, ay, {GUARD_BITS{1'b0}}});
  assign cz[0] = '0;

  generate
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      c2p_cordic_cell #(
        .XW    (XW),
        .STAGE (k)
      ) u_cell (
        .clk   (clk),
        .en    (en),
        .x_in  (cx[k]),
        .y_in  (cy[k]),
        .z_in  (cz[k]),
        .x_out (cx[k+1]),
        .y_out (cy[k+1]),
        .z_out (cz[k+1])
      );
    end
  endgenerate

  quad_flags_t flags_u;

  c2p_delay #(
    .WIDTH ($bits(quad_flags_t)),
    .DEPTH (CORDIC_STAGES + 1)
  ) u_flag_pipe (
    .clk (clk),
    .en  (en),
    .d   (flags_a),
    .q   (flags_u)
  );

  // clamp to [0, 90] degrees, then round to the output step
  logic [ATAN_W-1:0] z_clamped;
  logic [AW-1:0]     a_round;
  logic [AW-1:0]     a_fq;

  always_comb begin
    priority if (cz[CORDIC_STAGES][ZW-1]) begin
      z_clamped = '0;
    end else if (cz[CORDIC_STAGES] > signed'({2'b00, DEG90_Z})) begin
      z_clamped = DEG90_Z;
    end else begin
      z_clamped = cz[CORDIC_STAGES][ATAN_W-1:0];
    end
  end

  generate
    if (SH > 0) begin : g_round
      logic [ATAN_W:0] z_half;
      assign z_half  = {1'b0, z_clamped} + ((ATAN_W+1)'(1) << (SH - 1));
      assign a_round = AW'(z_half >> SH);
    end else begin : g_exact
      assign a_round = AW'(z_clamped);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      a_fq <= a_round;
    end
  end

  // unfold to the full circle; axes are exact
  logic [AW-1:0] ang_next;
  logic [AW-1:0] ang;
  logic          zero;
  logic [AW:0]   ang_al;

  always_comb begin
    priority if (flags_u.x_zero && flags_u.y_zero) begin
      ang_next = '0;
    end else if (flags_u.x_zero) begin
      ang_next = flags_u.y_neg ? A270 : A90;
    end else if (flags_u.y_zero) begin
      ang_next = flags_u.x_neg ? A180 : '0;
    end else if (!flags_u.x_neg && !flags_u.y_neg) begin
      ang_next = a_fq;
    end else if (flags_u.x_neg && !flags_u.y_neg) begin
      ang_next = A180 - a_fq;
    end else if (flags_u.x_neg) begin
      ang_next = A180 + a_fq;
    end else if (a_fq == '0) begin
      ang_next = '0;          // 360 wraps to 0
    end else begin
      ang_next = A360 - a_fq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang  <= ang_next;
      zero <= flags_u.x_zero & flags_u.y_zero;
    end
  end

  c2p_delay #(
    .WIDTH (AW + 1),
    .DEPTH (TOT - ANG_LAT)
  ) u_ang_pad (
    .clk (clk),
    .en  (en),
    .d   ({zero, ang}),
    .q   (ang_al)
  );

  // ---- output queue
  logic [OUT_W-1:0] res_out;

  c2p_out_buf #(
    .WIDTH (OUT_W)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (en & vld[TOT-1]),
    .push_data ({rad_al, ang_al}),
    .space     (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res_out)
  );

  assign radius       = res_out[OUT_W-1 -: W];
  assign radius_zero  = res_out[AW];
  assign angle_deg_q8 = res_out[AW-1:0];

endmodule

`default_nettype wire

FILE: test/cartesian_to_polar_top_tb.sv
// Self-checking testbench for the pipelined Cartesian-to-polar converter.
`timescale 1ns / 1ps

module cartesian_to_polar_top_tb;

  localparam int COORD_W    = 16;
  localparam int STAGES     = 18;
  localparam int FRAC       = 8;
  localparam int ANGLE_W    = FRAC + 9;
  localparam int GUARD      = 28;
  localparam int ZFRAC      = 16;
  localparam int ATAN_LEN   = 32;
  localparam longint DEG90_Q16 = 64'd5898240;
  localparam int LATENCY    = 22;
  localparam int DRAIN      = 2 * LATENCY;
  localparam int HOLD_LEN   = 200;
  localparam int IDLE_LIMIT = 1000;
  localparam int MAX_GAP    = 5;

  // atan(2^-i) in degrees, Q16
  localparam longint ATAN_Q16 [ATAN_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COORD_W-1:0]        radius;
    logic [ANGLE_W-1:0]        angle;
    logic                      zero;
  } polar_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] x_coord = '0;
  logic signed [COORD_W-1:0] y_coord = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [COORD_W-1:0]        radius;
  logic [ANGLE_W-1:0]        angle_deg_q8;
  logic                      radius_zero;

  polar_t pending_polar[$];
  int     sent_cnt = 0;
  int     recv_cnt = 0;
  int     err_cnt = 0;
  int     idle_cycles = 0;
  bit     burst_mode = 1'b0;
  bit     hold_req = 1'b0;
  int     hold_cnt = 0;

  cartesian_to_polar_top #(
    .COORD_WIDTH    (COORD_W),
    .CORDIC_STAGES  (STAGES),
    .ANGLE_FRAC_BITS(FRAC)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .radius      (radius),
    .angle_deg_q8(angle_deg_q8),
    .radius_zero (radius_zero)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Exact rounded radius plus folded CORDIC angle
  function automatic polar_t polar_of(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y);
    polar_t            p;
    longint            sx, sy, cx, cy, cz, dx, dy, ang, a;
    longint unsigned   ax, ay, n, r, b;
    int                sh;
    p.x = x;
    p.y = y;
    sx = longint'(x);
    sy = longint'(y);
    ax = (sx < 0) ? longint'(-sx) : sx;
    ay = (sy < 0) ? longint'(-sy) : sy;
    if (sx == 0 && sy == 0) begin
      p.radius = '0;
      p.angle  = '0;
      p.zero   = 1'b1;
      return p;
    end
    if (sx == 0) begin
      ang = (sy > 0) ? (90 << FRAC) : (270 << FRAC);
    end else if (sy == 0) begin
      ang = (sx > 0) ? 0 : (180 << FRAC);
    end else begin
      cx = longint'(ax << GUARD);
      cy = longint'(ay << GUARD);
      cz = 0;
      for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx = cx + dx;
          cy = cy - dy;
          cz = cz + ATAN_Q16[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          cz = cz - ATAN_Q16[i];
        end
      end
      if (cz < 0) cz = 0;
      if (cz > DEG90_Q16) cz = DEG90_Q16;
      sh = (FRAC < ZFRAC) ? ZFRAC - FRAC : 0;
      a  = (sh == 0) ? cz : ((cz + (longint'(1) << (sh - 1))) >>> sh);
      if (sx > 0 && sy > 0)      ang = a;
      else if (sx < 0 && sy > 0) ang = (180 << FRAC) - a;
      else if (sx < 0)           ang = (180 << FRAC) + a;
      else                       ang = (360 << FRAC) - a;
      if (ang >= (360 << FRAC)) ang = ang - (360 << FRAC);
    end
    // bitwise integer square root, then round up when the remainder exceeds the root
    n = ax * ax + ay * ay;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n > r) r = r + 1;
    p.radius = r[COORD_W-1:0];
    p.angle  = ang[ANGLE_W-1:0];
    p.zero   = 1'b0;
    return p;
  endfunction

  // One input transfer; valid stays high across back-to-back items
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_coord  <= x;
    y_coord  <= y;
    do @(posedge clk); while (!in_ready);
    pending_polar.push_back(polar_of(x, y));
    sent_cnt++;
  endtask

  function automatic logic signed [COORD_W-1:0] pick_extreme();
    case ($urandom_range(0, 6))
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      5: return 16'sd32766;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_span(input int span);
    return COORD_W'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic send_random_point();
    logic signed [COORD_W-1:0] x, y;
    logic signed [COORD_W-1:0] m;
    x = COORD_W'($urandom());
    y = COORD_W'($urandom());
    case ($urandom_range(0, 9))
      4: begin
        x = pick_span(8);
        y = pick_span(8);
      end
      5: if ($urandom_range(0, 1)) x = '0; else y = '0;
      6: if ($urandom_range(0, 1)) x = pick_span(3); else y = pick_span(3);
      7: begin
        x = pick_extreme();
        y = pick_extreme();
      end
      8: begin
        m = COORD_W'($urandom_range(0, 32767));
        x = $urandom_range(0, 1) ? -m : m;
        y = $urandom_range(0, 1) ? -m : m;
      end
      9: begin
        x = pick_span(1024);
        y = pick_span(1024);
      end
      default: ;
    endcase
    send_point(x, y);
  endtask

  task automatic test_directed_points();
    send_point(16'sd0, 16'sd0);
    send_point(16'sd32767, 16'sd0);
    send_point(-16'sd32768, 16'sd0);
    send_point(16'sd0, 16'sd32767);
    send_point(16'sd0, -16'sd32768);
    send_point(16'sd1, 16'sd0);
    send_point(16'sd0, -16'sd1);
    send_point(16'sd1, 16'sd1);
    send_point(-16'sd1, 16'sd1);
    send_point(-16'sd1, -16'sd1);
    send_point(16'sd1, -16'sd1);
    send_point(16'sd32767, 16'sd32767);
    send_point(-16'sd32768, 16'sd32767);
    send_point(-16'sd32768, -16'sd32768);
    send_point(16'sd32767, -16'sd32768);
    // tiny fourth-quadrant angle: rounding to zero wraps 360 back to 0
    send_point(16'sd32767, -16'sd1);
    send_point(16'sd20000, -16'sd1);
    send_point(-16'sd32768, -16'sd1);
    send_point(-16'sd32768, 16'sd1);
    send_point(16'sd1, 16'sd32767);
    send_point(-16'sd1, -16'sd32768);
    send_point(16'sd3, 16'sd4);
  endtask

  task automatic test_random_points(input int count);
    for (int i = 0; i < count; i++) send_random_point();
  endtask

  task automatic test_burst_points(input int count);
    burst_mode = 1'b1;
    for (int i = 0; i < count; i++) send_random_point();
    burst_mode = 1'b0;
  endtask

  // receiver stalls long enough for the pipeline and its output queue to fill
  task automatic test_output_hold(input int count);
    burst_mode = 1'b1;
    hold_req   = 1'b1;
    for (int i = 0; i < count; i++) send_random_point();
    burst_mode = 1'b0;
  endtask

  // Receiver: random ready gaps, compare each result transfer with the oldest prediction
  initial begin
    polar_t exp_p;
    int     gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_LEN; hold_cnt++) @(posedge clk);
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      recv_cnt++;
      if (pending_polar.size() == 0) begin
        $display("%0t: result with nothing outstanding: radius %0d angle %0d zero %0b",
                 $time, radius, angle_deg_q8, radius_zero);
        err_cnt++;
      end else begin
        exp_p = pending_polar.pop_front();
        if (radius !== exp_p.radius) begin
          $display("%0t: radius (x=%0d y=%0d) expected %0d actual %0d",
                   $time, exp_p.x, exp_p.y, exp_p.radius, radius);
          err_cnt++;
        end
        if (angle_deg_q8 !== exp_p.angle) begin
          $display("%0t: angle_deg_q8 (x=%0d y=%0d) expected %0d actual %0d",
                   $time, exp_p.x, exp_p.y, exp_p.angle, angle_deg_q8);
          err_cnt++;
        end
        if (radius_zero !== exp_p.zero) begin
          $display("%0t: radius_zero (x=%0d y=%0d) expected %0b actual %0b",
                   $time, exp_p.x, exp_p.y, exp_p.zero, radius_zero);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_polar.size());
      $display("FAIL cartesian_to_polar_top");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_points();
    test_random_points(950);
    test_burst_points(200);
    test_output_hold(180);
    in_valid <= 1'b0;
    while (pending_polar.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Sent %0d points, checked %0d results: axes, all quadrants, extremes,", sent_cnt,
             recv_cnt);
    $display("random idling on both sides, back-to-back bursts and a %0d-cycle output hold.",
             HOLD_LEN);
    if (err_cnt == 0 && pending_polar.size() == 0) begin
      $display("PASS cartesian_to_polar_top");
    end else begin
      $display("FAIL cartesian_to_polar_top");
    end
    $finish;
  end

endmodule
